// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition must hold at every edge out of reset.
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ----- rtl/pid_pkg.sv -----
// Shared widths, codes and controller/datapath signal groups of the PID step core.
package pid_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int INTEG_W     = 64;
  localparam int ACC_W       = 65;
  localparam int FRAC_W      = 16;
  localparam int FULL_W      = 96;
  localparam int Q_W         = FULL_W - FRAC_W;
  localparam int DIVIDEND_W  = DATA_W + 1 + FRAC_W;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_UPDATE    = 2'd0;
  localparam logic [OP_W-1:0] OP_START     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_INT = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D   = 4'd3;

  // Which product the shared multiplier is working on
  typedef logic [1:0] term_sel_t;
  localparam term_sel_t TERM_INC = 2'd0;
  localparam term_sel_t TERM_P   = 2'd1;
  localparam term_sel_t TERM_I   = 2'd2;
  localparam term_sel_t TERM_D   = 2'd3;

  typedef struct packed {
    logic      capture;
    logic      clear_integral;
    logic      load_ops;
    term_sel_t sel;
    logic      mul_lo;
    logic      mul_hi;
    logic      round;
    logic      integ_add;
    logic      acc_load;
    logic      acc_add;
    logic      div_load;
    logic      div_step;
    logic      rate_set;
    logic      rate_zero;
    logic      emit;
  } pid_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dt_zero;
  } pid_status_t;

endpackage

// ----- rtl/pid_req_if.sv -----
// Request channel: operation, process value and elapsed time.
interface pid_req_if import pid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic signed [DATA_W-1:0] process_value;
  logic [DATA_W-1:0] delta_time;

  modport source (output valid, output operation, output process_value,
                  output delta_time, input ready);
  modport sink   (input valid, input operation, input process_value,
                  input delta_time, output ready);
endinterface

// ----- rtl/pid_rsp_if.sv -----
// Result channel: drive value and its flags.
interface pid_rsp_if import pid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [DATA_W-1:0] drive_value;
  logic              saturated;
  logic              zero_interval;

  modport source (output valid, output drive_value, output saturated,
                  output zero_interval, input ready);
  modport sink   (input valid, input drive_value, input saturated,
                  input zero_interval, output ready);
endinterface

// ----- rtl/pid_datapath.sv -----
// PID datapath: registers, shared multiplier, rounding, serial divider, output stage.
module pid_datapath import pid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] process_value,
  input  logic [DATA_W-1:0]        delta_time,
  input  pid_cmd_t                 cmd,
  output pid_status_t              status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] drive_value,
  output logic                     saturated,
  output logic                     zero_interval
);

  localparam logic [DATA_W-1:0]  MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [INTEG_W-1:0] MAX64 = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] MIN64 = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic [FULL_W-1:0]  BIAS_POS = 96'h8000;
  localparam logic [FULL_W-1:0]  BIAS_NEG = 96'h7FFF;
  localparam logic [Q_W-1:0]     TERM_LIMIT = 80'd1 << 62;
  localparam logic [DIVIDEND_W-1:0] RATE_NEG_LIMIT = 49'h0_8000_0000;
  localparam logic [DIVIDEND_W-1:0] RATE_POS_LIMIT = 49'h0_7FFF_FFFF;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [INTEG_W-1:0] mag64(input logic [INTEG_W-1:0] x);
    return x[INTEG_W-1] ? (~x + 64'd1) : x;
  endfunction

  // Control-reset state
  logic [DATA_W-1:0]  setpoint, gain_p, gain_i, gain_d;
  logic [DATA_W-1:0]  last_error;
  logic [INTEG_W-1:0] integral;

  // Payload state
  logic [DATA_W-1:0]     err, dt, rate, ma, rem, drive;
  logic [INTEG_W-1:0]    mb, plo, phi, term;
  logic [ACC_W-1:0]      acc;
  logic [DIVIDEND_W-1:0] dq;
  logic                  neg, clip, zdt, de_neg, sat_out, zdt_out;

  // Combinational values
  logic [DATA_W:0]      diff, de, dmag, rem2, rdiff;
  logic                 diff_ovf, ge, drive_ovf, integ_ovf;
  logic [DATA_W-1:0]    err_next, mult_b, drive_next;
  logic [INTEG_W-1:0]   prod, qs, term_next;
  logic [FULL_W-1:0]    full;
  logic [Q_W-1:0]       q, qc;
  logic [INTEG_W:0]     isum;
  logic [ACC_W-1:0]     acc_sum;

  always_comb begin
    diff     = {setpoint[DATA_W-1], setpoint} - {process_value[DATA_W-1], process_value};
    diff_ovf = diff[DATA_W] != diff[DATA_W-1];
    err_next = diff_ovf ? (diff[DATA_W] ? MIN32 : MAX32) : diff[DATA_W-1:0];

    mult_b = cmd.mul_hi ? mb[INTEG_W-1:DATA_W] : mb[DATA_W-1:0];
    prod   = ma * mult_b;

    full      = {phi, 32'd0} + {32'd0, plo} + (neg ? BIAS_NEG : BIAS_POS);
    q         = full[FULL_W-1:FRAC_W];
    qc        = (q > TERM_LIMIT) ? TERM_LIMIT : q;
    qs        = qc[INTEG_W-1:0];
    term_next = neg ? (64'd0 - qs) : qs;

    isum      = {integral[INTEG_W-1], integral} + {term[INTEG_W-1], term};
    integ_ovf = isum[INTEG_W] != isum[INTEG_W-1];
    acc_sum   = acc + {term[INTEG_W-1], term};

    de   = {err[DATA_W-1], err} - {last_error[DATA_W-1], last_error};
    dmag = de[DATA_W] ? (~de + 33'd1) : de;

    rem2  = {rem, dq[DIVIDEND_W-1]};
    rdiff = rem2 - {1'b0, dt};
    ge    = rem2 >= {1'b0, dt};

    drive_ovf  = acc[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){acc[DATA_W-1]}};
    drive_next = drive_ovf ? (acc[ACC_W-1] ? MIN32 : MAX32) : acc[DATA_W-1:0];
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.dt_zero  = dt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= '0;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      last_error <= '0;
      integral   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SETPOINT: setpoint <= cfg_data;
          REG_GAIN_P:   gain_p   <= cfg_data;
          REG_GAIN_I:   gain_i   <= cfg_data;
          REG_GAIN_D:   gain_d   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_integral) begin
        integral <= '0;
      end else if (cmd.integ_add) begin
        integral <= integ_ovf ? (isum[INTEG_W] ? MIN64 : MAX64) : isum[INTEG_W-1:0];
      end
      if (cmd.emit) begin
        last_error <= err;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err  <= err_next;
      clip <= diff_ovf;
      zdt  <= 1'b0;
      dt   <= delta_time;
    end
    if (cmd.load_ops) begin
      case (cmd.sel)
        TERM_INC: begin
          ma  <= dt;
          mb  <= {32'd0, mag32(err)};
          neg <= err[DATA_W-1];
        end
        TERM_P: begin
          ma  <= mag32(gain_p);
          mb  <= {32'd0, mag32(err)};
          neg <= gain_p[DATA_W-1] ^ err[DATA_W-1];
        end
        TERM_I: begin
          ma  <= mag32(gain_i);
          mb  <= mag64(integral);
          neg <= gain_i[DATA_W-1] ^ integral[INTEG_W-1];
        end
        default: begin
          ma  <= mag32(gain_d);
          mb  <= {32'd0, mag32(rate)};
          neg <= gain_d[DATA_W-1] ^ rate[DATA_W-1];
        end
      endcase
    end
    if (cmd.mul_lo) plo <= prod;
    if (cmd.mul_hi) phi <= prod;
    if (cmd.round)  term <= term_next;
    if (cmd.integ_add && integ_ovf) clip <= 1'b1;
    if (cmd.acc_load) begin
      acc <= {term[INTEG_W-1], term};
    end else if (cmd.acc_add) begin
      acc <= acc_sum;
    end
    if (cmd.div_load) begin
      de_neg <= de[DATA_W];
      dq     <= {dmag, 16'd0};
      rem    <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? rdiff[DATA_W-1:0] : rem2[DATA_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], ge};
    end
    if (cmd.rate_zero) begin
      rate <= '0;
      zdt  <= 1'b1;
    end else if (cmd.rate_set) begin
      if (de_neg) begin
        if (dq > RATE_NEG_LIMIT) begin
          rate <= MIN32;
          clip <= 1'b1;
        end else begin
          rate <= 32'd0 - dq[DATA_W-1:0];
        end
      end else begin
        if (dq > RATE_POS_LIMIT) begin
          rate <= MAX32;
          clip <= 1'b1;
        end else begin
          rate <= dq[DATA_W-1:0];
        end
      end
    end
    if (cmd.emit) begin
      drive   <= drive_next;
      sat_out <= clip | drive_ovf;
      zdt_out <= zdt;
    end
  end

  assign drive_value   = drive;
  assign saturated     = sat_out;
  assign zero_interval = zdt_out;

endmodule

// ----- rtl/pid_ctrl.sv -----
// PID sequencer: steps the datapath through the products, the division and the result.
module pid_ctrl import pid_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_operation,
  output logic            req_ready,
  input  pid_status_t     status,
  output pid_cmd_t        cmd
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_MLO    = 4'd2;
  localparam logic [3:0] S_MHI    = 4'd3;
  localparam logic [3:0] S_ROUND  = 4'd4;
  localparam logic [3:0] S_USE    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_RATE   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]       state, state_next;
  term_sel_t        term, term_next;
  logic             is_start, is_start_next;
  logic [CNT_W-1:0] count, count_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next    = state;
    term_next     = term;
    is_start_next = is_start;
    count_next    = count;
    cmd           = '0;
    cmd.sel       = term;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_operation)
            OP_UPDATE: begin
              cmd.capture   = 1'b1;
              term_next     = TERM_INC;
              is_start_next = 1'b0;
              state_next    = S_LOAD;
            end
            OP_START: begin
              cmd.capture        = 1'b1;
              cmd.clear_integral = 1'b1;
              term_next          = TERM_P;
              is_start_next      = 1'b1;
              state_next         = S_LOAD;
            end
            OP_CLEAR_INT: cmd.clear_integral = 1'b1;
            OP_UNUSED: ;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_ops = 1'b1;
        state_next   = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_USE;
      end
      S_USE: begin
        unique case (term)
          TERM_INC: begin
            cmd.integ_add = 1'b1;
            if (status.dt_zero) begin
              cmd.rate_zero = 1'b1;
              term_next     = TERM_P;
              state_next    = S_LOAD;
            end else begin
              cmd.div_load = 1'b1;
              count_next   = '0;
              state_next   = S_DIV;
            end
          end
          TERM_P: begin
            cmd.acc_load = 1'b1;
            if (is_start) begin
              state_next = S_FINISH;
            end else begin
              term_next  = TERM_I;
              state_next = S_LOAD;
            end
          end
          TERM_I: begin
            cmd.acc_add = 1'b1;
            term_next   = TERM_D;
            state_next  = S_LOAD;
          end
          default: begin
            cmd.acc_add = 1'b1;
            state_next  = S_FINISH;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + 1'b1;
        if (count == CNT_LAST) state_next = S_RATE;
      end
      S_RATE: begin
        cmd.rate_set = 1'b1;
        term_next    = TERM_P;
        state_next   = S_LOAD;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      term     <= TERM_INC;
      is_start <= 1'b0;
      count    <= '0;
    end else begin
      state    <= state_next;
      term     <= term_next;
      is_start <= is_start_next;
      count    <= count_next;
    end
  end

endmodule

// ----- rtl/pid_controller_step_core.sv -----
// A start forms the proportional product and writes the result; an update forms the
// integral increment, divides for the rate unless the interval is zero, then forms the
// three gain products. Clear-integral and unused codes are taken while idle and give no
// result. One request at a time: the next is accepted the cycle after the result is
// written; the 49-step serial divider, shared 32x32 multiplier and output stalls set the pace.
// Reset (synchronous, active high) clears gains, setpoint, last error, integral and the
// result valid flag; no clearing pass is needed.
`include "assert_macros.svh"

module pid_controller_step_core import pid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  pid_req_if.sink                req,
  pid_rsp_if.source              rsp
);

  pid_cmd_t    cmd;
  pid_status_t status;
  logic [4:0]  unit_use;

  // Sequencer: takes a request when idle, then walks the error capture, the integral
  // increment, rate division and gain products (only P for a start), one product at a time.
  pid_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .status        (status),
    .cmd           (cmd)
  );

  // Datapath: configuration registers, loop state, the shared multiplier with its
  // half-up rounding, the restoring divider and the result register. The result
  // register parts the two sides: a finished result waits there while the next
  // request is already being worked on; only the final write waits for it to drain.
  pid_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .process_value (req.process_value),
    .delta_time    (req.delta_time),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .drive_value   (rsp.drive_value),
    .saturated     (rsp.saturated),
    .zero_interval (rsp.zero_interval)
  );

  assign unit_use = {cmd.mul_lo, cmd.mul_hi, cmd.round, cmd.div_step, cmd.emit};

  // Never overwrite a result that has not been taken.
  `ASSERT_IMPLY(a_emit_into_free_slot, clk, rst, cmd.emit, status.out_free, "result overwritten")
  // A written result shows on the output in the next cycle.
  `ASSERT_NEXT(a_emit_shows_result, clk, rst, cmd.emit, rsp.valid, "result not presented")
  // The multiplier, rounding, divider and output stage are used one at a time.
  `ASSERT_HOLDS(a_one_unit_busy, clk, rst, $onehot0(unit_use), "datapath units overlap")
  // No request is taken while the divider is stepping.
  `ASSERT_IMPLY(a_busy_no_request, clk, rst, cmd.div_step, !req.ready, "request taken while busy")

endmodule
